FILE: rtl/core/pfl_pkg.sv
// ----------------------------------------------------------------------------
// pfl_pkg
// shared types and constants of the physical page free list
// ----------------------------------------------------------------------------
package pfl_pkg;

   // fixed field widths of the transaction payloads and registers
   localparam int CFG_W          = 13;
   localparam int PAGE_FIELD_W   = 12;
   localparam int COUNT_FIELD_W  = 13;
   localparam int REQ_KIND_W     = 2;
   localparam int STATUS_W       = 2;
   localparam int CSR_INDEX_W    = 2;

   // request kinds
   localparam logic [REQ_KIND_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_KIND_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_KIND_W-1:0] REQ_INIT  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PAGES    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_FIRST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_END   = 2'd2;

   localparam logic [CFG_W-1:0] TOTAL_PAGES_RESET = 13'd4096;

   typedef struct packed {
      logic [REQ_KIND_W-1:0]   req_type;
      logic [PAGE_FIELD_W-1:0] page_number;
   } pfl_req_type;

   typedef struct packed {
      logic [PAGE_FIELD_W-1:0]  granted_page;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_FIELD_W-1:0] free_count;
   } pfl_rsp_type;

   // init page walker status toward the controller
   typedef struct packed {
      logic busy;
      logic push;
      logic last;
   } pfl_walk_status_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ALLOC = 4'b0010,
      S_INIT  = 4'b0100,
      S_HOLD  = 4'b1000
   } pfl_state_type;

endpackage

FILE: rtl/core/pfl_ram.sv
// ----------------------------------------------------------------------------
// pfl_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pfl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pfl_page_walk.sv
// ----------------------------------------------------------------------------
// pfl_page_walk
// steps through pages 0 .. limit-1, one a cycle, flagging reserved pages
// ----------------------------------------------------------------------------
module pfl_page_walk #(
   parameter int PAGE_W = 12,
   parameter int CMP_W  = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [CMP_W-1:0]             limit,
   input  logic [CMP_W-1:0]             rsv_first,
   input  logic [CMP_W-1:0]             rsv_end,
   output logic [PAGE_W-1:0]            page,
   output pfl_pkg::pfl_walk_status_type walk_status
);

   logic              busy_ff, busy_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [CMP_W-1:0]  page_cmp;
   logic              reserved;
   logic              last;

   assign page_cmp = CMP_W'(page_ff);
   assign reserved = (page_cmp >= rsv_first) && (page_cmp < rsv_end);
   assign last     = busy_ff && (page_cmp == (limit - CMP_W'(1)));

   always_comb begin
      busy_in = busy_ff;
      page_in = page_ff;
      if (start) begin
         busy_in = 1'b1;
         page_in = '0;
      end else if (busy_ff) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            page_in = page_ff + PAGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      page_ff <= page_in;
   end

   assign page             = page_ff;
   assign walk_status.busy = busy_ff;
   assign walk_status.push = busy_ff && !reserved;
   assign walk_status.last = last;

endmodule

FILE: rtl/core/physical_page_free_list.sv
// ----------------------------------------------------------------------------
// physical_page_free_list
// lifo free list of physical pages, linked through a next-link ram
// ----------------------------------------------------------------------------
// sequence: free, empty allocate and unknown requests form their result on
//   acceptance; allocate first reads the link of the head page from the ram;
//   init runs the walker, one page pushed per cycle; each result is registered
// one transaction at a time: a new request is taken only from idle, once the
//   previous result has gone into the output register
// reset: list empty, head 0, registers at their reset values; the link ram
//   is not cleared (no clearing pass), entries are written before being read
module physical_page_free_list #(
   parameter int NUM_PAGES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pfl_pkg::pfl_req_type                req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pfl_pkg::pfl_rsp_type                rsp_data,
   // register write port
   input  logic                                csr_we,
   input  logic [pfl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pfl_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int PAGE_W  = $clog2(NUM_PAGES);
   localparam int CNT_W   = $clog2(NUM_PAGES + 1);
   localparam int CFG_W   = pfl_pkg::CFG_W;
   localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int GRANT_W = pfl_pkg::PAGE_FIELD_W;
   localparam int FCNT_W  = pfl_pkg::COUNT_FIELD_W;

   // configuration registers
   logic [CFG_W-1:0] total_pages_ff, total_pages_in;
   logic [CFG_W-1:0] rsv_first_ff, rsv_first_in;
   logic [CFG_W-1:0] rsv_end_ff, rsv_end_in;

   // list state and control
   pfl_pkg::pfl_state_type state_ff, state_in;
   logic [PAGE_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pfl_pkg::pfl_rsp_type   rsp_data_ff, rsp_data_in;
   pfl_pkg::pfl_rsp_type   hold_ff, hold_in;

   // link ram ports
   logic              mem_we;
   logic [PAGE_W-1:0] mem_waddr;
   logic [PAGE_W-1:0] mem_wdata;
   logic              mem_re;
   logic [PAGE_W-1:0] mem_rdata;

   // init walker
   logic                         walk_start;
   logic [PAGE_W-1:0]            walk_page;
   pfl_pkg::pfl_walk_status_type walk_status;

   // per-transaction helpers
   logic                           req_accept;
   logic                           slot_free;
   logic [CMP_W-1:0]               total_ext;
   logic [CMP_W-1:0]               eff_pages;
   logic                           free_range_err;
   logic [PAGE_W-1:0]              freed_page;
   logic [CNT_W-1:0]               count_inc;
   logic                           res_ready;
   logic [PAGE_W-1:0]              res_page;
   logic [pfl_pkg::STATUS_W-1:0]   res_status;
   pfl_pkg::pfl_rsp_type           res_data;

   // ---------------------------------------------------------------------------
   // register writes, indexes beyond the list are dropped
   // ---------------------------------------------------------------------------
   always_comb begin
      total_pages_in = total_pages_ff;
      rsv_first_in   = rsv_first_ff;
      rsv_end_in     = rsv_end_ff;
      if (csr_we) begin
         case (csr_index)
            pfl_pkg::CSR_TOTAL_PAGES:    total_pages_in = csr_wdata;
            pfl_pkg::CSR_RESERVED_FIRST: rsv_first_in   = csr_wdata;
            pfl_pkg::CSR_RESERVED_END:   rsv_end_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // effective page count: total_pages capped at the ram depth
   assign total_ext = CMP_W'(total_pages_ff);
   assign eff_pages = (total_ext > CMP_W'(NUM_PAGES)) ? CMP_W'(NUM_PAGES) : total_ext;

   // a request is taken only from idle, a pending result does not block it
   assign req_stall  = (state_ff != pfl_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   assign free_range_err = (CMP_W'(req_data.page_number) >= eff_pages);
   assign freed_page     = PAGE_W'(req_data.page_number);

   // double free is not caught, the count just saturates
   assign count_inc = (count_ff == CNT_W'(NUM_PAGES)) ? count_ff : count_ff + CNT_W'(1);

   // ---------------------------------------------------------------------------
   // sequencer: pop through a link read, push through a link write
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      mem_we     = 1'b0;
      mem_waddr  = head_ff;
      mem_wdata  = head_ff;
      mem_re     = 1'b0;
      walk_start = 1'b0;
      res_ready  = 1'b0;
      res_page   = '0;
      res_status = pfl_pkg::ST_OK;

      case (state_ff)
         pfl_pkg::S_IDLE: begin
            if (req_accept) begin
               case (req_data.req_type)
                  pfl_pkg::REQ_ALLOC: begin
                     if (count_ff == '0) begin
                        res_ready  = 1'b1;
                        res_status = pfl_pkg::ST_EMPTY;
                     end else begin
                        // fetch the link of the head page
                        mem_re   = 1'b1;
                        state_in = pfl_pkg::S_ALLOC;
                     end
                  end
                  pfl_pkg::REQ_FREE: begin
                     res_ready = 1'b1;
                     if (free_range_err) begin
                        res_status = pfl_pkg::ST_RANGE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = freed_page;
                        head_in   = freed_page;
                        count_in  = count_inc;
                     end
                  end
                  pfl_pkg::REQ_INIT: begin
                     head_in  = '0;
                     count_in = '0;
                     if (eff_pages == '0) begin
                        res_ready = 1'b1;
                     end else begin
                        walk_start = 1'b1;
                        state_in   = pfl_pkg::S_INIT;
                     end
                  end
                  default: begin
                     // unknown request: no state change
                     res_ready = 1'b1;
                  end
               endcase
            end
         end
         pfl_pkg::S_ALLOC: begin
            head_in   = mem_rdata;
            count_in  = count_ff - CNT_W'(1);
            res_page  = head_ff;
            res_ready = 1'b1;
         end
         pfl_pkg::S_INIT: begin
            // walker pushes each unreserved page, highest ends on top
            if (walk_status.push) begin
               mem_we    = 1'b1;
               mem_waddr = walk_page;
               head_in   = walk_page;
               count_in  = count_inc;
            end
            if (walk_status.last) begin
               res_ready = 1'b1;
            end
         end
         pfl_pkg::S_HOLD: ;
         default: state_in = pfl_pkg::S_IDLE;
      endcase

      res_data.granted_page = GRANT_W'(res_page);
      res_data.status       = res_status;
      res_data.free_count   = FCNT_W'(count_in);

      // result delivery: straight into the output register, or parked
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      hold_in      = hold_ff;
      if (state_ff == pfl_pkg::S_HOLD) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = hold_ff;
            state_in     = pfl_pkg::S_IDLE;
         end
      end else if (res_ready) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_data;
            state_in     = pfl_pkg::S_IDLE;
         end else begin
            hold_in  = res_data;
            state_in = pfl_pkg::S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff <= pfl_pkg::TOTAL_PAGES_RESET;
         rsv_first_ff   <= '0;
         rsv_end_ff     <= '0;
         state_ff       <= pfl_pkg::S_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         total_pages_ff <= total_pages_in;
         rsv_first_ff   <= rsv_first_in;
         rsv_end_ff     <= rsv_end_in;
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      hold_ff     <= hold_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // next-link ram and init walker
   // ---------------------------------------------------------------------------
   pfl_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (NUM_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (head_ff),
      .rd_data (mem_rdata)
   );

   pfl_page_walk #(
      .PAGE_W (PAGE_W),
      .CMP_W  (CMP_W)
   ) u_page_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (walk_start),
      .limit       (eff_pages),
      .rsv_first   (CMP_W'(rsv_first_ff)),
      .rsv_end     (CMP_W'(rsv_end_ff)),
      .page        (walk_page),
      .walk_status (walk_status)
   );

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   // the sequencer only sits in init while the walker runs
   a_init_walker_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfl_pkg::S_INIT) |-> walk_status.busy)
      else $error("init state without an active page walk");

   // a pop always removes exactly one page
   a_alloc_decrements: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfl_pkg::S_ALLOC) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("allocate did not decrement the free count");

   // a link read is only issued for a non-empty list
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (count_ff != '0) && (state_ff == pfl_pkg::S_IDLE))
      else $error("link read issued on an empty list");

   // an out-of-range free leaves the head alone
   a_range_err_no_push: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.req_type == pfl_pkg::REQ_FREE) && free_range_err)
      |=> (head_ff == $past(head_ff)) && (count_ff == $past(count_ff)))
      else $error("out-of-range free changed the list");

endmodule

FILE: bench/physical_page_free_list_checker.sv
// ----------------------------------------------------------------------------
// physical_page_free_list_checker
// watches the request, result and register ports of the page free list,
// keeps its own linked free list and compares every result in order
// ----------------------------------------------------------------------------
module physical_page_free_list_checker #(
   parameter int NUM_PAGES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  pfl_pkg::pfl_req_type             req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  pfl_pkg::pfl_rsp_type             rsp_data,
   input  logic                             csr_we,
   input  logic [pfl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pfl_pkg::CFG_W-1:0]        csr_wdata,
   output int                               mismatch_count,
   output int                               awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_W = pfl_pkg::PAGE_FIELD_W;
   localparam int FCNT_W = pfl_pkg::COUNT_FIELD_W;
   localparam int CFG_W  = pfl_pkg::CFG_W;

   // mirror of the list
   logic [PAGE_W-1:0] link_ram [NUM_PAGES];
   logic [PAGE_W-1:0] head_page;
   int unsigned       listed_pages;

   // mirror of the registers
   logic [CFG_W-1:0] cfg_total;
   logic [CFG_W-1:0] cfg_first;
   logic [CFG_W-1:0] cfg_end;

   pfl_pkg::pfl_rsp_type predicted_rsp_q [$];

   function automatic int unsigned usable_pages();
      return (cfg_total > NUM_PAGES) ? NUM_PAGES : 32'(cfg_total);
   endfunction

   // double frees are pushed again, the count saturates
   function automatic void push_page(int unsigned page);
      logic [PAGE_W-1:0] pg;
      pg = page[PAGE_W-1:0];
      link_ram[pg] = head_page;
      head_page = pg;
      if (listed_pages < NUM_PAGES) listed_pages++;
   endfunction

   function automatic pfl_pkg::pfl_rsp_type serve_request(pfl_pkg::pfl_req_type req);
      pfl_pkg::pfl_rsp_type res;
      int unsigned lim;
      res.granted_page = '0;
      res.status       = pfl_pkg::ST_OK;
      lim = usable_pages();
      case (req.req_type)
         pfl_pkg::REQ_ALLOC: begin
            if (listed_pages == 0) begin
               res.status = pfl_pkg::ST_EMPTY;
            end else begin
               res.granted_page = head_page;
               head_page = link_ram[head_page];
               listed_pages--;
            end
         end
         pfl_pkg::REQ_FREE: begin
            if (32'(req.page_number) >= lim) res.status = pfl_pkg::ST_RANGE;
            else push_page(32'(req.page_number));
         end
         pfl_pkg::REQ_INIT: begin
            head_page = '0;
            listed_pages = 0;
            for (int unsigned p = 0; p < lim; p++) begin
               if (p < cfg_first || p >= cfg_end) push_page(p);
            end
         end
         default: ;
      endcase
      res.free_count = listed_pages[FCNT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      pfl_pkg::pfl_rsp_type want;
      if (reset) begin
         head_page    = '0;
         listed_pages = 0;
         cfg_total    = pfl_pkg::TOTAL_PAGES_RESET;
         cfg_first    = '0;
         cfg_end      = '0;
         predicted_rsp_q.delete();
      end else begin
         // results first: a request taken at this edge cannot answer here
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result page %0d status %0d count %0d",
                           $time, rsp_data.granted_page, rsp_data.status,
                           rsp_data.free_count);
            end else begin
               want = predicted_rsp_q.pop_front();
               if (rsp_data.granted_page !== want.granted_page ||
                   rsp_data.status !== want.status ||
                   rsp_data.free_count !== want.free_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: page/status/count expected %0d/%0d/%0d got %0d/%0d/%0d",
                              $time, want.granted_page, want.status, want.free_count,
                              rsp_data.granted_page, rsp_data.status,
                              rsp_data.free_count);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               pfl_pkg::CSR_TOTAL_PAGES:    cfg_total = csr_wdata;
               pfl_pkg::CSR_RESERVED_FIRST: cfg_first = csr_wdata;
               pfl_pkg::CSR_RESERVED_END:   cfg_end   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predicted_rsp_q.push_back(serve_request(req_data));
      end
      awaited_count = predicted_rsp_q.size();
   end

endmodule

FILE: bench/physical_page_free_list_test.sv
// ----------------------------------------------------------------------------
// physical_page_free_list_test
// drives alloc, free and init transactions into the page free list under
// several register settings, with random gaps and stalls on both channels;
// a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module physical_page_free_list_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PAGES = 4096;
   localparam int PAGE_W    = pfl_pkg::PAGE_FIELD_W;
   localparam int CFG_W     = pfl_pkg::CFG_W;
   localparam int KIND_W    = pfl_pkg::REQ_KIND_W;
   // request code the block does not know, answered without a state change
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   // cycles with no transaction anywhere before the run is declared hung
   localparam int STALL_LIMIT = 20000;
   // length of the one long receiver hold-off
   localparam int LONG_HOLD = 400;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 200;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   pfl_pkg::pfl_req_type                req_data;
   logic                                rsp_valid;
   logic                                rsp_stall;
   pfl_pkg::pfl_rsp_type                rsp_data;
   logic                                csr_we;
   logic [pfl_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [CFG_W-1:0]                    csr_wdata;

   int mismatch_count;
   int awaited_count;
   int req_taken = 0;     // requests accepted by the block
   int rsp_taken = 0;     // results accepted from the block
   int quiet_cycles = 0;  // cycles since the last transaction
   bit calm = 1'b0;       // no gaps and no stalls while set
   int shadow_total = 32'(pfl_pkg::TOTAL_PAGES_RESET);

   physical_page_free_list #(
      .NUM_PAGES(NUM_PAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   physical_page_free_list_checker #(
      .NUM_PAGES(NUM_PAGES)
   ) free_list_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // results taken by the receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_taken <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_taken <= rsp_taken + 1;
      end
   end

   // watchdog: any transaction or register write restarts the count
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: mostly short stalls, a few long ones, and one long hold-off
   // once the run is well under way so that the block fills up
   initial begin
      int span;
      int roll;
      bit held_off;
      held_off = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         if (!held_off && rsp_taken >= 300) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 8);
            end else if (roll < 95) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               span = $urandom_range(4, 40);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   // one transaction: optional gap, then hold valid until accepted;
   // valid stays high on return so back to back items need no dip
   task automatic send_req(input logic [KIND_W-1:0] kind,
                           input logic [PAGE_W-1:0] page);
      int gap;
      int roll;
      gap = 0;
      if (!calm) begin
         roll = $urandom_range(0, 99);
         if (roll >= 92) gap = $urandom_range(4, 30);
         else if (roll >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, page_number: page};
      do @(posedge clock); while (req_stall);
      req_taken++;
   endtask

   // sender pauses until every result is back, block then idle
   task automatic drain();
      req_valid <= 1'b0;
      while (rsp_taken != req_taken) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all three registers in consecutive cycles, only while idle
   task automatic write_regs(input int total, input int first, input int last);
      csr_we    <= 1'b1;
      csr_index <= pfl_pkg::CSR_TOTAL_PAGES;
      csr_wdata <= total[CFG_W-1:0];
      @(posedge clock);
      csr_index <= pfl_pkg::CSR_RESERVED_FIRST;
      csr_wdata <= first[CFG_W-1:0];
      @(posedge clock);
      csr_index <= pfl_pkg::CSR_RESERVED_END;
      csr_wdata <= last[CFG_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_total = total;
   endtask

   initial begin
      int total;
      int first;
      int last;
      int usable;
      int alloc_bias;
      int roll;
      int pick;
      logic [PAGE_W-1:0] page;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= pfl_pkg::CSR_TOTAL_PAGES;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, registers at reset values ---
      send_req(pfl_pkg::REQ_ALLOC, 12'hFFF);     // empty list after reset
      send_req(pfl_pkg::REQ_FREE, 12'd4095);     // highest page
      send_req(pfl_pkg::REQ_FREE, 12'd0);        // lowest page
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);       // empty again
      send_req(REQ_UNUSED, 12'hFFF);             // unknown code, no state change
      send_req(pfl_pkg::REQ_INIT, 12'h555);      // full list of every page
      send_req(pfl_pkg::REQ_FREE, 12'hABC);      // double free, count saturates
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);

      // small list with a reserved hole, frees at and past the end
      drain();
      write_regs(10, 3, 6);
      send_req(pfl_pkg::REQ_INIT, 12'd0);
      send_req(pfl_pkg::REQ_FREE, 12'd10);
      send_req(pfl_pkg::REQ_FREE, 12'd4095);
      send_req(pfl_pkg::REQ_FREE, 12'd9);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);

      // zero pages: init gives an empty list, every free is out of range
      drain();
      write_regs(0, 0, 0);
      send_req(pfl_pkg::REQ_INIT, 12'd0);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);
      send_req(pfl_pkg::REQ_FREE, 12'd0);

      // reserved bounds reversed, nothing kept off
      drain();
      write_regs(5, 4, 2);
      send_req(pfl_pkg::REQ_INIT, 12'd0);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);

      // page count above the array is capped, empty reserved range
      drain();
      write_regs(8191, 8191, 8191);
      send_req(pfl_pkg::REQ_INIT, 12'd0);
      send_req(pfl_pkg::REQ_FREE, 12'd4095);

      // whole range reserved
      drain();
      write_regs(4096, 0, 8191);
      send_req(pfl_pkg::REQ_INIT, 12'd0);
      send_req(pfl_pkg::REQ_ALLOC, 12'd0);

      // --- random phases, one register setting each ---
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin total = 8191; first = 0; last = 0; end
            1: begin total = 1; first = 0; last = 0; end
            2: begin total = 4096; first = 100; last = 4000; end
            3: begin total = 64; first = 8191; last = 0; end
            default: begin
               total = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(2, 96);
               usable = (total > NUM_PAGES) ? NUM_PAGES : total;
               first = $urandom_range(0, usable + 2);
               last  = $urandom_range(0, usable + 2);
            end
         endcase
         calm = (phase == 5);
         write_regs(total, first, last);
         usable = (shadow_total > NUM_PAGES) ? NUM_PAGES : shadow_total;
         send_req(pfl_pkg::REQ_INIT, PAGE_W'($urandom));
         alloc_bias = 50;

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // runs of alloc-heavy and free-heavy traffic to drain and refill
            if (i % 20 == 0) begin
               case ($urandom_range(0, 2))
                  0: alloc_bias = 25;
                  1: alloc_bias = 50;
                  default: alloc_bias = 75;
               endcase
            end
            if ($urandom_range(0, 199) == 0) drain();
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               send_req(pfl_pkg::REQ_INIT, PAGE_W'($urandom));
            end else if (roll < 4) begin
               send_req(REQ_UNUSED, PAGE_W'($urandom));
            end else if ($urandom_range(0, 99) < alloc_bias) begin
               send_req(pfl_pkg::REQ_ALLOC, PAGE_W'($urandom));
            end else begin
               // mostly pages in range, some just past the end, some anywhere
               pick = $urandom_range(0, 99);
               if (usable > 0 && pick < 88)
                  page = PAGE_W'($urandom_range(0, usable - 1));
               else if (usable < NUM_PAGES && pick < 96)
                  page = PAGE_W'($urandom_range(usable, (usable + 3 > NUM_PAGES - 1) ?
                                                        NUM_PAGES - 1 : usable + 3));
               else
                  page = PAGE_W'($urandom);
               send_req(pfl_pkg::REQ_FREE, page);
            end
         end
      end
      calm = 1'b0;

      // wait for the last results, then a few idle cycles
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
